// ----- rtl/sis_pkg.sv -----
// ----------------------------------------------------------------------------
// sis_pkg
// Shared types and constants of the segmented insertion sorter.
// ----------------------------------------------------------------------------
`default_nettype none

package sis_pkg;

  localparam int unsigned MaxGroupDef = 64;
  localparam int unsigned KeyBitsDef  = 16;
  localparam int unsigned LsW         = 16;
  localparam int unsigned PayloadW    = 64;
  localparam int unsigned NumPayload  = 4;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SHIFT,
    ST_PLACE,
    ST_EMIT
  } sis_state_e;

  typedef struct packed {
    logic we;
    logic re;
  } sis_mem_ctl_t;

endpackage

`default_nettype wire

// ----- rtl/sis_mem.sv -----
// ----------------------------------------------------------------------------
// sis_mem
// Record store: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module sis_mem
  import sis_pkg::*;
#(
  parameter int unsigned Depth = MaxGroupDef,
  parameter int unsigned AddrW = $clog2(MaxGroupDef),
  parameter int unsigned DataW = KeyBitsDef + NumPayload * PayloadW
) (
  input  logic               clk_i,
  input  sis_mem_ctl_t       ctl_i,
  input  logic [AddrW-1:0]   waddr_i,
  input  logic [AddrW-1:0]   raddr_i,
  input  logic [DataW-1:0]   wdata_i,
  output logic [DataW-1:0]   rdata_o
);

  logic [DataW-1:0] mem_q [Depth];
  logic [DataW-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (ctl_i.we) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.re) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// ----- rtl/sis_ctrl.sv -----
// ----------------------------------------------------------------------------
// sis_ctrl
// Insertion and emission sequencer: shifts larger records up one slot per
// cycle, places the new record, and reads the group out in order.
// ----------------------------------------------------------------------------
`default_nettype none

module sis_ctrl
  import sis_pkg::*;
#(
  parameter int unsigned MaxGroup = MaxGroupDef,
  parameter int unsigned KeyBits  = KeyBitsDef,
  parameter int unsigned AddrW    = $clog2(MaxGroupDef),
  parameter int unsigned CntW     = $clog2(MaxGroupDef + 1),
  parameter int unsigned DataW    = KeyBitsDef + NumPayload * PayloadW
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start,
  input  logic [DataW-1:0]   rec_i,
  input  logic               group_end_i,
  output logic               busy,
  output sis_mem_ctl_t       mem_ctl_o,
  output logic [AddrW-1:0]   waddr_o,
  output logic [AddrW-1:0]   raddr_o,
  output logic [DataW-1:0]   wdata_o,
  input  logic [DataW-1:0]   rdata_i,
  output logic               out_valid_o,
  output logic               out_last_o,
  output logic               out_drop_o
);

  sis_state_e       state_q, state_d;
  logic [CntW-1:0]  fill_q, fill_d;
  logic             drop_q, drop_d;
  logic [AddrW-1:0] ptr_q, ptr_d;
  logic [DataW-1:0] rec_q, rec_d;
  logic             end_q, end_d;
  logic             vld_q, vld_d;
  logic             last_q, last_d;
  logic             odrop_q, odrop_d;

  logic [KeyBits-1:0] rd_key;
  logic [KeyBits-1:0] new_key;
  logic [CntW-1:0]    fill_dec;
  logic               emit_last;

  assign rd_key    = rdata_i[DataW-1 -: KeyBits];
  assign new_key   = rec_q[DataW-1 -: KeyBits];
  assign fill_dec  = fill_q - CntW'(1);
  assign emit_last = (CntW'(ptr_q) + CntW'(1)) == fill_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      fill_q  <= '0;
      drop_q  <= 1'b0;
      vld_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      fill_q  <= fill_d;
      drop_q  <= drop_d;
      vld_q   <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ptr_q   <= ptr_d;
    rec_q   <= rec_d;
    end_q   <= end_d;
    last_q  <= last_d;
    odrop_q <= odrop_d;
  end

  always_comb begin
    state_d   = state_q;
    fill_d    = fill_q;
    drop_d    = drop_q;
    ptr_d     = ptr_q;
    rec_d     = rec_q;
    end_d     = end_q;
    vld_d     = 1'b0;
    last_d    = last_q;
    odrop_d   = odrop_q;
    mem_ctl_o = '0;
    raddr_o   = ptr_q;
    waddr_o   = ptr_q;
    wdata_o   = rec_q;

    case (state_q)
      ST_IDLE: begin
        if (start) begin
          rec_d = rec_i;
          end_d = group_end_i;
          if (fill_q == CntW'(MaxGroup)) begin
            drop_d = 1'b1;
            ptr_d  = '0;
            if (group_end_i) begin
              state_d = ST_EMIT;
            end
          end else if (fill_q == '0) begin
            ptr_d   = '0;
            state_d = ST_PLACE;
          end else begin
            mem_ctl_o.re = 1'b1;
            raddr_o      = fill_dec[AddrW-1:0];
            ptr_d        = fill_dec[AddrW-1:0];
            state_d      = ST_SHIFT;
          end
        end
      end

      ST_SHIFT: begin
        mem_ctl_o.we = 1'b1;
        waddr_o      = ptr_q + AddrW'(1);
        if (rd_key > new_key) begin
          wdata_o = rdata_i;
          if (ptr_q == '0) begin
            state_d = ST_PLACE;
          end else begin
            mem_ctl_o.re = 1'b1;
            raddr_o      = ptr_q - AddrW'(1);
            ptr_d        = ptr_q - AddrW'(1);
          end
        end else begin
          wdata_o = rec_q;
          fill_d  = fill_q + CntW'(1);
          ptr_d   = '0;
          state_d = end_q ? ST_EMIT : ST_IDLE;
        end
      end

      ST_PLACE: begin
        mem_ctl_o.we = 1'b1;
        waddr_o      = ptr_q;
        wdata_o      = rec_q;
        fill_d       = fill_q + CntW'(1);
        ptr_d        = '0;
        state_d      = end_q ? ST_EMIT : ST_IDLE;
      end

      ST_EMIT: begin
        mem_ctl_o.re = 1'b1;
        raddr_o      = ptr_q;
        vld_d        = 1'b1;
        last_d       = emit_last;
        odrop_d      = drop_q;
        if (emit_last) begin
          fill_d  = '0;
          drop_d  = 1'b0;
          state_d = ST_IDLE;
        end else begin
          ptr_d = ptr_q + AddrW'(1);
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  assign busy        = state_q != ST_IDLE;
  assign out_valid_o = vld_q;
  assign out_last_o  = last_q;
  assign out_drop_o  = odrop_q;

endmodule

`default_nettype wire

// ----- rtl/segmented_insertion_sorter_unit.sv -----
// ----------------------------------------------------------------------------
// segmented_insertion_sorter_unit
// Stable insertion sort of keyed records, emitted per group in key order.
// ----------------------------------------------------------------------------
// An item is taken when start is high and busy is low. Insertion walks the
// store from the top down through the single read port of the record memory,
// one stored record per cycle with busy high, moving each larger record up
// one slot; it stops above the first key that is not larger, or lands in
// slot 0 (the first item of a group goes to slot 0 directly). An item that
// arrives with the group full is dropped; busy stays low unless it ends the
// group. On a group end the n stored records are read out one per cycle
// while busy stays high, each result marked by out_valid_o for exactly one
// cycle, in the cycle after its read. Results cannot be held off; the receiver
// takes each in its cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module segmented_insertion_sorter_unit
  import sis_pkg::*;
#(
  parameter int unsigned MaxGroup = MaxGroupDef,
  parameter int unsigned KeyBits  = KeyBitsDef
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start,
  output logic                busy,
  input  logic [LsW-1:0]      litter_size_i,
  input  logic [PayloadW-1:0] pos_count_i,
  input  logic [PayloadW-1:0] neg_count_i,
  input  logic [PayloadW-1:0] pos_prob_i,
  input  logic [PayloadW-1:0] expected_val_i,
  input  logic                group_end_i,
  output logic                out_valid_o,
  output logic [LsW-1:0]      out_litter_size_o,
  output logic [PayloadW-1:0] out_pos_count_o,
  output logic [PayloadW-1:0] out_neg_count_o,
  output logic [PayloadW-1:0] out_pos_prob_o,
  output logic [PayloadW-1:0] out_expected_val_o,
  output logic                last_of_group_o,
  output logic                overflowed_o
);

  localparam int unsigned AddrW = $clog2(MaxGroup);
  localparam int unsigned CntW  = $clog2(MaxGroup + 1);
  localparam int unsigned DataW = KeyBits + NumPayload * PayloadW;
  localparam int unsigned KeyIn = (KeyBits < LsW) ? KeyBits : LsW;

  logic [KeyBits-1:0] key_in;
  logic [DataW-1:0]   rec_in;
  sis_mem_ctl_t       mem_ctl;
  logic [AddrW-1:0]   waddr;
  logic [AddrW-1:0]   raddr;
  logic [DataW-1:0]   wdata;
  logic [DataW-1:0]   rdata;
  logic [KeyBits-1:0] rd_key;

  assign key_in = KeyBits'(litter_size_i[KeyIn-1:0]);
  assign rec_in = {key_in, pos_count_i, neg_count_i, pos_prob_i, expected_val_i};

  sis_ctrl #(
    .MaxGroup (MaxGroup),
    .KeyBits  (KeyBits),
    .AddrW    (AddrW),
    .CntW     (CntW),
    .DataW    (DataW)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start       (start),
    .rec_i       (rec_in),
    .group_end_i (group_end_i),
    .busy        (busy),
    .mem_ctl_o   (mem_ctl),
    .waddr_o     (waddr),
    .raddr_o     (raddr),
    .wdata_o     (wdata),
    .rdata_i     (rdata),
    .out_valid_o (out_valid_o),
    .out_last_o  (last_of_group_o),
    .out_drop_o  (overflowed_o)
  );

  sis_mem #(
    .Depth (MaxGroup),
    .AddrW (AddrW),
    .DataW (DataW)
  ) u_mem (
    .clk_i   (clk_i),
    .ctl_i   (mem_ctl),
    .waddr_i (waddr),
    .raddr_i (raddr),
    .wdata_i (wdata),
    .rdata_o (rdata)
  );

  assign rd_key             = rdata[DataW-1 -: KeyBits];
  assign out_litter_size_o  = LsW'(rd_key[KeyIn-1:0]);
  assign out_pos_count_o    = rdata[4*PayloadW-1 -: PayloadW];
  assign out_neg_count_o    = rdata[3*PayloadW-1 -: PayloadW];
  assign out_pos_prob_o     = rdata[2*PayloadW-1 -: PayloadW];
  assign out_expected_val_o = rdata[PayloadW-1:0];

  a_strobe_while_busy : assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> $past(busy)
  ) else $error("result strobe without a preceding emission cycle");

  a_gap_after_last : assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && last_of_group_o) |=> !out_valid_o
  ) else $error("result strobe right after the last item of a group");

  a_idle_after_last : assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && last_of_group_o) |-> !busy
  ) else $error("busy held after last item of a group");

endmodule

`default_nettype wire

// ----- tb/sv/tb_top.sv -----
// ----------------------------------------------------------------------------
// tb_top
// Checks the segmented insertion sorter. Records are sent one item at a
// time through the start/busy handshake, and a local sorted store predicts
// the group each group end must produce. Every strobed result is matched
// field by field against the oldest predicted one. Covered: key and payload
// extremes, single-record groups, equal keys in arrival order, insertion at
// the bottom of the store, full groups with dropped records, and random
// groups under several sender idle rates.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import sis_pkg::*;

  localparam int unsigned   KeyCmpW       = (KeyBitsDef < LsW) ? KeyBitsDef : LsW;
  localparam logic [LsW-1:0] KeyMask      = LsW'((64'd1 << KeyCmpW) - 64'd1);
  localparam int unsigned   WatchdogLimit = 1000;
  localparam int unsigned   DrainCycles   = 20;
  localparam int unsigned   MaxReports    = 10;

  typedef struct packed {
    logic [LsW-1:0]      key;
    logic [PayloadW-1:0] pa;
    logic [PayloadW-1:0] pb;
    logic [PayloadW-1:0] pc;
    logic [PayloadW-1:0] pd;
  } sort_rec_t;

  typedef struct packed {
    sort_rec_t rec;
    logic      last;
    logic      ovf;
  } sorted_out_t;

  logic                clk_i;
  logic                rst_ni          = 1'b0;
  logic                start           = 1'b0;
  logic                busy;
  logic [LsW-1:0]      litter_size_i   = '0;
  logic [PayloadW-1:0] pos_count_i     = '0;
  logic [PayloadW-1:0] neg_count_i     = '0;
  logic [PayloadW-1:0] pos_prob_i      = '0;
  logic [PayloadW-1:0] expected_val_i  = '0;
  logic                group_end_i     = 1'b0;
  logic                out_valid_o;
  logic [LsW-1:0]      out_litter_size_o;
  logic [PayloadW-1:0] out_pos_count_o;
  logic [PayloadW-1:0] out_neg_count_o;
  logic [PayloadW-1:0] out_pos_prob_o;
  logic [PayloadW-1:0] out_expected_val_o;
  logic                last_of_group_o;
  logic                overflowed_o;

  sort_rec_t   held_recs [MaxGroupDef];
  int unsigned held_cnt      = 0;
  logic        held_drop     = 1'b0;
  sorted_out_t pending_out[$];
  sorted_out_t want_out;
  int unsigned mismatch_cnt  = 0;
  int unsigned stall_cycles  = 0;
  int unsigned send_idle_pct = 0;

  segmented_insertion_sorter_unit #(
    .MaxGroup(MaxGroupDef),
    .KeyBits (KeyBitsDef)
  ) i_dut (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .start             (start),
    .busy              (busy),
    .litter_size_i     (litter_size_i),
    .pos_count_i       (pos_count_i),
    .neg_count_i       (neg_count_i),
    .pos_prob_i        (pos_prob_i),
    .expected_val_i    (expected_val_i),
    .group_end_i       (group_end_i),
    .out_valid_o       (out_valid_o),
    .out_litter_size_o (out_litter_size_o),
    .out_pos_count_o   (out_pos_count_o),
    .out_neg_count_o   (out_neg_count_o),
    .out_pos_prob_o    (out_pos_prob_o),
    .out_expected_val_o(out_expected_val_o),
    .last_of_group_o   (last_of_group_o),
    .overflowed_o      (overflowed_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  function automatic sort_rec_t make_rec(logic [LsW-1:0] key, logic [63:0] a, logic [63:0] b,
                                         logic [63:0] c, logic [63:0] d);
    sort_rec_t r;
    r.key = key;
    r.pa  = a;
    r.pb  = b;
    r.pc  = c;
    r.pd  = d;
    return r;
  endfunction

  // Insert after every held key <= new key; emit the whole group on group end.
  task automatic store_record(input sort_rec_t rec, input logic grp_end);
    int unsigned pos;
    sorted_out_t outcome;
    rec.key = rec.key & KeyMask;
    if (held_cnt < MaxGroupDef) begin
      pos = held_cnt;
      while (pos > 0 && held_recs[pos-1].key > rec.key) begin
        held_recs[pos] = held_recs[pos-1];
        pos--;
      end
      held_recs[pos] = rec;
      held_cnt++;
    end else begin
      held_drop = 1'b1;
    end
    if (grp_end) begin
      for (int unsigned k = 0; k < held_cnt; k++) begin
        outcome.rec  = held_recs[k];
        outcome.last = (k + 1 == held_cnt);
        outcome.ovf  = held_drop;
        pending_out.push_back(outcome);
      end
      held_cnt  = 0;
      held_drop = 1'b0;
    end
  endtask

  task automatic send_item(input sort_rec_t rec, input logic grp_end);
    int unsigned gap;
    if (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      gap = $urandom_range(3, 1);
      start <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    start          <= 1'b1;
    litter_size_i  <= rec.key;
    pos_count_i    <= rec.pa;
    neg_count_i    <= rec.pb;
    pos_prob_i     <= rec.pc;
    expected_val_i <= rec.pd;
    group_end_i    <= grp_end;
    do @(posedge clk_i); while (busy);
    store_record(rec, grp_end);
  endtask

  task automatic send_random_group(input int unsigned size, input bit narrow);
    logic [LsW-1:0] key;
    for (int unsigned i = 0; i < size; i++) begin
      key = narrow ? LsW'($urandom_range(7)) : LsW'($urandom_range(16'hFFFF));
      send_item(make_rec(key, rand64(), rand64(), rand64(), rand64()), i + 1 == size);
    end
  endtask

  task automatic flag_mismatch(input string what, input logic [63:0] want,
                               input logic [63:0] got);
    mismatch_cnt++;
    if (mismatch_cnt <= MaxReports)
      $display("%0t: %s mismatch: expected %h, got %h", $realtime, what, want, got);
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o) begin
      if (pending_out.size() == 0) begin
        flag_mismatch("unexpected result key", '0, 64'(out_litter_size_o));
      end else begin
        want_out = pending_out.pop_front();
        if (out_litter_size_o !== want_out.rec.key)
          flag_mismatch("out_litter_size", 64'(want_out.rec.key), 64'(out_litter_size_o));
        if (out_pos_count_o !== want_out.rec.pa)
          flag_mismatch("out_pos_count", want_out.rec.pa, out_pos_count_o);
        if (out_neg_count_o !== want_out.rec.pb)
          flag_mismatch("out_neg_count", want_out.rec.pb, out_neg_count_o);
        if (out_pos_prob_o !== want_out.rec.pc)
          flag_mismatch("out_pos_prob", want_out.rec.pc, out_pos_prob_o);
        if (out_expected_val_o !== want_out.rec.pd)
          flag_mismatch("out_expected_val", want_out.rec.pd, out_expected_val_o);
        if (last_of_group_o !== want_out.last)
          flag_mismatch("last_of_group", 64'(want_out.last), 64'(last_of_group_o));
        if (overflowed_o !== want_out.ovf)
          flag_mismatch("overflowed", 64'(want_out.ovf), 64'(overflowed_o));
      end
    end
  end

  always @(posedge clk_i) begin
    if ((start && !busy) || out_valid_o)
      stall_cycles <= 0;
    else
      stall_cycles <= stall_cycles + 1;
    if (stall_cycles >= WatchdogLimit) begin
      $display("Some tests failed");
      $finish;
    end
  end

  task automatic test_key_extremes();
    send_item(make_rec(16'hFFFF, '1, '1, '1, '1), 1'b0);
    send_item(make_rec(16'h0000, '0, '0, '0, '0), 1'b0);
    send_item(make_rec(16'h8000, {16{4'hA}}, {16{4'h5}}, {16{4'hA}}, {16{4'h5}}), 1'b0);
    send_item(make_rec(16'h7FFF, {16{4'h5}}, {16{4'hA}}, {16{4'h5}}, {16{4'hA}}), 1'b1);
  endtask

  task automatic test_single_record();
    send_item(make_rec(16'h1234, rand64(), rand64(), rand64(), rand64()), 1'b1);
  endtask

  task automatic test_stable_ties();
    logic [LsW-1:0] keys [7] = '{16'd7, 16'd3, 16'd7, 16'd7, 16'd3, 16'd9, 16'd7};
    for (int unsigned i = 0; i < 7; i++)
      send_item(make_rec(keys[i], 64'(i), 64'(i) << 8, 64'(i) << 16, 64'(i) << 24), i == 6);
  endtask

  task automatic test_descending();
    for (int unsigned i = 0; i < 7; i++)
      send_item(make_rec(LsW'(60 - 10 * i), rand64(), rand64(), rand64(), rand64()), i == 6);
  endtask

  task automatic test_overflow(input int unsigned extra);
    send_random_group(MaxGroupDef + extra, 1'b0);
  endtask

  task automatic test_drain_pause();
    send_random_group(5, 1'b0);
    start <= 1'b0;
    while (pending_out.size() != 0) @(posedge clk_i);
    send_random_group(3, 1'b1);
  endtask

  task automatic test_random_traffic(input int unsigned n_items, input int unsigned idle_pct);
    int unsigned sent;
    int unsigned size;
    sent          = 0;
    send_idle_pct = idle_pct;
    while (sent < n_items) begin
      size = ($urandom_range(9) == 0) ? $urandom_range(40, 12) : $urandom_range(8, 1);
      send_random_group(size, 1'($urandom_range(1)));
      sent += size;
    end
  endtask

  initial begin
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    send_idle_pct = 10;
    test_key_extremes();
    test_single_record();
    test_stable_ties();
    test_descending();
    test_overflow(0);
    test_overflow(3);
    test_drain_pause();
    test_random_traffic(50, 10);
    test_random_traffic(50, 46);
    test_random_traffic(50, 0);
    start <= 1'b0;
    while (pending_out.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    if (mismatch_cnt == 0)
      $display("All tests passed");
    else
      $display("Some tests failed");
    $finish;
  end

endmodule

`default_nettype wire
